// ===== sv/btpc_pkg.sv =====
package btpc_pkg;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    localparam logic [1:0] REG_TEMP       = 2'd0;
    localparam logic [1:0] REG_PRESS_LOW  = 2'd1;
    localparam logic [1:0] REG_PRESS_MID  = 2'd2;
    localparam logic [1:0] REG_PRESS_HIGH = 2'd3;

    localparam logic signed [14:0] TEMP_MIN  = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX  = 15'sd8500;
    localparam logic [24:0]        PRESS_MAX = 25'h1FFFFFF;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] P_BIAS      = 64'h0000_8000_0000_0000;
    localparam logic [63:0] P_SCALE     = 64'd3125;
    localparam logic [20:0] RAW_FULL    = 21'h100000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T1, S_T2, S_T3, S_TFIN,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_PCHK, S_P7,
        S_PDL, S_PDIV, S_PDF,
        S_P8, S_P9, S_P10, S_PFIN
    } t_state;

    function automatic logic [63:0] sx16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [63:0] zx16(input logic [15:0] x);
        return {48'd0, x};
    endfunction

endpackage

// ===== sv/baro_temp_pressure_compensation_unit.sv =====
// Operation: a temperature sample takes three shift-add multiplications, a pressure sample
// ten plus one divide that yields one quotient bit a cycle; a zero divisor ends a pressure
// sample after six multiplications with divide_guard set. A multiplication runs until its
// shifted multiplier reaches zero, so larger multipliers take longer.
// Throughput: one sample in flight; the next is taken once the result is registered.
// Reset (synchronous, active low) clears coefficients, fine temperature and control state.
module baro_temp_pressure_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [19:0] raw_sample, zero pad above
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [14:0] temperature_centi, [39:15] pressure_q8,
                                        // [40] divide_guard, zero pad above
    output logic        m_axis_tuser    // [0] result_kind
);
    import btpc_pkg::*;

    t_state r_state, n_state;
    logic [47:0] r_tc, r_pl, r_pm, r_ph;
    logic [31:0] r_fine, n_fine;
    logic [19:0] r_raw, n_raw;
    logic        r_kind, n_kind;
    logic [63:0] r_a, n_a, r_b, n_b, r_acc, n_acc;
    logic [63:0] r_v1, n_v1, r_v2, n_v2, r_m1, n_m1, r_p, n_p;
    logic        r_run, n_run;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic        r_ovalid, n_ovalid;
    logic        r_okind, n_okind;
    logic [14:0] r_otemp, n_otemp;
    logic [24:0] r_opress, n_opress;
    logic        r_oguard, n_oguard;

    logic        w_is_mul, w_done, w_ofree, w_in_xfer;
    logic [63:0] w_opa, w_opb, w_prod, w_rem, w_t, w_pf;
    logic signed [17:0] w_d1;
    logic signed [16:0] w_d2;
    logic [20:0] w_praw;

    assign w_in_xfer = s_axis_tvalid && s_axis_tready;
    assign w_ofree   = !r_ovalid || m_axis_tready;
    assign w_done    = r_run && (r_b == '0);
    assign w_prod    = r_acc;
    assign w_rem     = {r_acc[62:0], r_a[63]};
    assign w_d1      = $signed({1'b0, r_raw[19:3]}) - $signed({1'b0, r_tc[15:0], 1'b0});
    assign w_d2      = $signed({1'b0, r_raw[19:4]}) - $signed({1'b0, r_tc[15:0]});
    assign w_praw    = RAW_FULL - {1'b0, r_raw};
    assign w_t       = 64'($signed((r_v1 << 2) + r_v1 + 64'd128) >>> 8);
    assign w_pf      = 64'($signed(r_p + r_v1 + r_v2) >>> 8) + (sx16(r_ph[15:0]) << 4);

    always_comb begin
        w_is_mul = 1'b1;
        w_opa    = r_v1;
        w_opb    = r_v1;
        case (r_state)
            S_T1: begin
                w_opa = 64'(w_d1);
                w_opb = sx16(r_tc[31:16]);
            end
            S_T2: begin
                w_opa = 64'(w_d2);
                w_opb = 64'(w_d2);
            end
            S_T3: begin
                w_opa = r_m1;
                w_opb = sx16(r_tc[47:32]);
            end
            S_P1: begin
                w_opa = r_v1;
                w_opb = r_v1;
            end
            S_P2: begin
                w_opa = r_m1;
                w_opb = sx16(r_pm[47:32]);
            end
            S_P3: begin
                w_opa = r_v1;
                w_opb = sx16(r_pm[31:16]);
            end
            S_P4: begin
                w_opa = r_m1;
                w_opb = sx16(r_pl[47:32]);
            end
            S_P5: begin
                w_opa = r_v1;
                w_opb = sx16(r_pl[31:16]);
            end
            S_P6: begin
                w_opa = r_v1;
                w_opb = zx16(r_pl[15:0]);
            end
            S_P7: begin
                w_opa = ({43'd0, w_praw} << 31) - r_v2;
                w_opb = P_SCALE;
            end
            S_P8: begin
                w_opa = sx16(r_ph[47:32]);
                w_opb = 64'($signed(r_p) >>> 13);
            end
            S_P9: begin
                w_opa = r_m1;
                w_opb = 64'($signed(r_p) >>> 13);
            end
            S_P10: begin
                w_opa = sx16(r_ph[31:16]);
                w_opb = r_p;
            end
            default: begin
                w_is_mul = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) n_state = (s_axis_tuser == OP_TEMP) ? S_T1 : S_P1;
            end
            S_T1:   if (w_done) n_state = S_T2;
            S_T2:   if (w_done) n_state = S_T3;
            S_T3:   if (w_done) n_state = S_TFIN;
            S_TFIN: if (w_ofree) n_state = S_IDLE;
            S_P1:   if (w_done) n_state = S_P2;
            S_P2:   if (w_done) n_state = S_P3;
            S_P3:   if (w_done) n_state = S_P4;
            S_P4:   if (w_done) n_state = S_P5;
            S_P5:   if (w_done) n_state = S_P6;
            S_P6:   if (w_done) n_state = S_PCHK;
            S_PCHK: begin
                if (r_v1 != '0) n_state = S_P7;
                else if (w_ofree) n_state = S_IDLE;
            end
            S_P7:   if (w_done) n_state = S_PDL;
            S_PDL:  n_state = S_PDIV;
            S_PDIV: if (r_cnt == 6'h3F) n_state = S_PDF;
            S_PDF:  n_state = S_P8;
            S_P8:   if (w_done) n_state = S_P9;
            S_P9:   if (w_done) n_state = S_P10;
            S_P10:  if (w_done) n_state = S_PFIN;
            S_PFIN: if (w_ofree) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_fine   = r_fine;
        n_raw    = r_raw;
        n_kind   = r_kind;
        n_a      = r_a;
        n_b      = r_b;
        n_acc    = r_acc;
        n_v1     = r_v1;
        n_v2     = r_v2;
        n_m1     = r_m1;
        n_p      = r_p;
        n_run    = r_run;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_okind  = r_okind;
        n_otemp  = r_otemp;
        n_opress = r_opress;
        n_oguard = r_oguard;

        if (w_is_mul) begin
            if (!r_run) begin
                n_a   = w_opa;
                n_b   = w_opb;
                n_acc = '0;
                n_run = 1'b1;
            end else if (!w_done) begin
                n_acc = r_acc + (r_b[0] ? r_a : 64'd0);
                n_a   = r_a << 1;
                n_b   = r_b >> 1;
            end else begin
                n_run = 1'b0;
                case (r_state)
                    S_T1:  n_v1 = 64'($signed(w_prod) >>> 11);
                    S_T2:  n_m1 = 64'($signed(w_prod) >>> 12);
                    S_T3:  n_v1 = r_v1 + 64'($signed(w_prod) >>> 14);
                    S_P1:  n_m1 = w_prod;
                    S_P2:  n_v2 = w_prod;
                    S_P3:  n_v2 = r_v2 + (w_prod << 17) + (sx16(r_pm[15:0]) << 35);
                    S_P4:  n_m1 = 64'($signed(w_prod) >>> 8);
                    S_P5:  n_v1 = r_m1 + (w_prod << 12) + P_BIAS;
                    S_P6:  n_v1 = 64'($signed(w_prod) >>> 33);
                    S_P7:  n_p  = w_prod;
                    S_P8:  n_m1 = w_prod;
                    S_P9:  n_v1 = 64'($signed(w_prod) >>> 25);
                    S_P10: n_v2 = 64'($signed(w_prod) >>> 19);
                    default: n_p = r_p;
                endcase
            end
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_raw  = s_axis_tdata[19:0];
                    n_kind = s_axis_tuser;
                    n_run  = 1'b0;
                    n_v1   = {{32{r_fine[31]}}, r_fine} - FINE_OFFSET;
                end
            end
            S_TFIN: begin
                if (w_ofree) begin
                    n_fine   = r_v1[31:0];
                    n_ovalid = 1'b1;
                    n_okind  = r_kind;
                    n_opress = '0;
                    n_oguard = 1'b0;
                    if ($signed(w_t) < $signed(64'(TEMP_MIN)))      n_otemp = TEMP_MIN;
                    else if ($signed(w_t) > $signed(64'(TEMP_MAX))) n_otemp = TEMP_MAX;
                    else                                            n_otemp = w_t[14:0];
                end
            end
            S_PCHK: begin
                if (r_v1 == '0 && w_ofree) begin
                    n_ovalid = 1'b1;
                    n_okind  = r_kind;
                    n_otemp  = '0;
                    n_opress = '0;
                    n_oguard = 1'b1;
                end
            end
            S_PDL: begin
                n_a   = r_p[63] ? (64'd0 - r_p) : r_p;
                n_b   = r_v1[63] ? (64'd0 - r_v1) : r_v1;
                n_acc = '0;
                n_cnt = '0;
                n_neg = r_p[63] ^ r_v1[63];
            end
            S_PDIV: begin
                n_cnt = r_cnt + 6'd1;
                if (w_rem >= r_b) begin
                    n_acc = w_rem - r_b;
                    n_a   = {r_a[62:0], 1'b1};
                end else begin
                    n_acc = w_rem;
                    n_a   = {r_a[62:0], 1'b0};
                end
            end
            S_PDF: begin
                n_p = r_neg ? (64'd0 - r_a) : r_a;
            end
            S_PFIN: begin
                if (w_ofree) begin
                    n_ovalid = 1'b1;
                    n_okind  = r_kind;
                    n_otemp  = '0;
                    n_oguard = 1'b0;
                    if (w_pf[63])                        n_opress = '0;
                    else if (w_pf > {39'd0, PRESS_MAX})  n_opress = PRESS_MAX;
                    else                                 n_opress = w_pf[24:0];
                end
            end
            default: begin
                n_neg = r_neg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tc     <= '0;
            r_pl     <= '0;
            r_pm     <= '0;
            r_ph     <= '0;
            r_fine   <= '0;
            r_run    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fine   <= n_fine;
            r_run    <= n_run;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TEMP:       r_tc <= i_cfg_data;
                    REG_PRESS_LOW:  r_pl <= i_cfg_data;
                    REG_PRESS_MID:  r_pm <= i_cfg_data;
                    REG_PRESS_HIGH: r_ph <= i_cfg_data;
                    default:        r_tc <= r_tc;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw    <= n_raw;
        r_kind   <= n_kind;
        r_a      <= n_a;
        r_b      <= n_b;
        r_acc    <= n_acc;
        r_v1     <= n_v1;
        r_v2     <= n_v2;
        r_m1     <= n_m1;
        r_p      <= n_p;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_okind  <= n_okind;
        r_otemp  <= n_otemp;
        r_opress <= n_opress;
        r_oguard <= n_oguard;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {7'd0, r_oguard, r_opress, r_otemp};

endmodule
